// ===== rtl/core/lane_byte_histogram_correlator_assert.svh =====
// Assertion macros for the checker file of the lane byte histogram correlator.
// Depends on nothing; the including module provides i_clk and i_rst_n.
`ifndef LANE_BYTE_HISTOGRAM_CORRELATOR_ASSERT_SVH
`define LANE_BYTE_HISTOGRAM_CORRELATOR_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define LBHC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define LBHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lbhc_pkg.sv =====
// Shared constants, types and pair tables of the lane byte histogram correlator.
// Depends on nothing.
package lbhc_pkg;

    localparam int COUNT_BITS = 32;
    localparam int LANES      = 4;
    localparam int LANE_W     = 2;
    localparam int BINS       = 256;
    localparam int BIN_W      = 8;
    localparam int ADDR_W     = LANE_W + BIN_W;
    localparam int DEPTH      = LANES * BINS;
    localparam int TOTAL_W    = 34;
    localparam int SUM_W      = 64;
    localparam int NPAIRS     = 10;
    localparam int PAIR_W     = 4;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX = '1;
    localparam logic [PAIR_W-1:0]     LAST_PAIR = PAIR_W'(NPAIRS - 1);

    typedef struct packed {
        logic clr;
        logic valid;
    } t_mac_ctl;

    function automatic logic [LANE_W-1:0] f_pair_a(input logic [PAIR_W-1:0] k);
        logic [LANE_W-1:0] r;
        case (k)
            4'd0, 4'd4, 4'd5, 4'd6: r = 2'd0;
            4'd1, 4'd7, 4'd8:       r = 2'd1;
            4'd2, 4'd9:             r = 2'd2;
            4'd3:                   r = 2'd3;
            default:                r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [LANE_W-1:0] f_pair_b(input logic [PAIR_W-1:0] k);
        logic [LANE_W-1:0] r;
        case (k)
            4'd0:                   r = 2'd0;
            4'd1, 4'd4:             r = 2'd1;
            4'd2, 4'd5, 4'd7:       r = 2'd2;
            4'd3, 4'd6, 4'd8, 4'd9: r = 2'd3;
            default:                r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/lbhc_hist_mem.sv =====
// Histogram store: one write port and two registered read ports.
// Depends on lbhc_pkg.
module lbhc_hist_mem (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [lbhc_pkg::ADDR_W-1:0]       i_waddr,
    input  logic [lbhc_pkg::COUNT_BITS-1:0]   i_wdata,
    input  logic [lbhc_pkg::ADDR_W-1:0]       i_raddr0,
    input  logic [lbhc_pkg::ADDR_W-1:0]       i_raddr1,
    output logic [lbhc_pkg::COUNT_BITS-1:0]   o_rdata0,
    output logic [lbhc_pkg::COUNT_BITS-1:0]   o_rdata1
);
    import lbhc_pkg::*;

    logic [COUNT_BITS-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

// ===== rtl/core/lbhc_mac.sv =====
// Multiply-accumulate unit for the bin product sums, saturating at 64 bits.
// Depends on lbhc_pkg.
module lbhc_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lbhc_pkg::t_mac_ctl                i_ctl,
    input  logic [lbhc_pkg::COUNT_BITS-1:0]   i_cnt_a,
    input  logic [lbhc_pkg::COUNT_BITS-1:0]   i_cnt_b,
    output logic [lbhc_pkg::SUM_W-1:0]        o_sum,
    output logic                              o_busy
);
    import lbhc_pkg::*;

    logic [SUM_W-1:0] r_prod;
    logic             r_pv;
    logic [SUM_W-1:0] r_acc;
    logic [SUM_W:0]   n_add;

    // A 32 by 32 product always fits in 64 bits; only the sum can overflow.
    assign n_add = {1'b0, r_acc} + {1'b0, r_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_pv <= i_ctl.valid;
            if (i_ctl.clr) begin
                r_acc <= '0;
            end else if (r_pv) begin
                r_acc <= n_add[SUM_W] ? '1 : n_add[SUM_W-1:0];
            end
        end
        r_prod <= SUM_W'(i_cnt_a) * SUM_W'(i_cnt_b);
    end

    assign o_sum  = r_acc;
    assign o_busy = r_pv;

endmodule

// ===== rtl/core/lane_byte_histogram_correlator.sv =====
// Four-lane byte histogram with a pairwise correlation report.
// Depends on lbhc_pkg, lbhc_hist_mem and lbhc_mac.
//
// After reset the block sweeps the 1024-entry histogram memory to zero, one
// entry a cycle, and holds o_in_stall high throughout the sweep. Count words
// can then be taken back to back: the histogram bin is read, incremented and
// written back over a two-stage path, with forwarding when the same bin is hit
// in consecutive cycles. A report word walks the 256 bins of each lane pair
// through the two read ports of the memory and a multiply-accumulate unit;
// each pair's result waits downstream until it is taken, and intake is stalled
// throughout the report.
module lane_byte_histogram_correlator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_lane_a,
    output logic [1:0]  o_lane_b,
    output logic [63:0] o_product_sum,
    output logic [31:0] o_total_a,
    output logic [31:0] o_total_b,
    output logic [7:0]  o_min_a,
    output logic [7:0]  o_max_a,
    output logic        o_last
);
    import lbhc_pkg::*;

    typedef enum logic [2:0] {S_CLEAR, S_RUN, S_RD, S_DRAIN, S_OUT} t_state;

    t_state               r_state;
    logic [ADDR_W-1:0]    r_clr_addr;
    logic [TOTAL_W-1:0]   r_byte_total;
    logic [7:0]           r_lane_min [LANES];
    logic [7:0]           r_lane_max [LANES];
    logic                 r_c_valid;
    logic [ADDR_W-1:0]    r_c_addr;
    logic                 r_c_fwd;
    logic [COUNT_BITS-1:0] r_c_fwd_val;
    logic [PAIR_W-1:0]    r_pair;
    logic [BIN_W-1:0]     r_bin;
    logic                 r_rv;

    logic                  accept_in, count_go, rep_go, out_take;
    logic [LANE_W-1:0]     cnt_lane, pa, pb;
    logic [ADDR_W-1:0]     cnt_addr, raddr0, raddr1, waddr;
    logic [COUNT_BITS-1:0] rdata0, rdata1, old_cnt, inc_cnt, wdata;
    logic                  we;
    t_mac_ctl              mac_ctl;
    logic [SUM_W-1:0]      mac_sum;
    logic                  mac_busy;

    function automatic logic [31:0] f_lane_total(input logic [TOTAL_W-1:0] bt,
                                                 input logic [LANE_W-1:0] m);
        logic [TOTAL_W:0] s;
        logic [TOTAL_W-2:0] t;
        s = {1'b0, bt} + (TOTAL_W+1)'(3) - (TOTAL_W+1)'(m);
        t = s[TOTAL_W:2];
        return t[TOTAL_W-2] ? 32'hFFFF_FFFF : t[31:0];
    endfunction

    assign o_in_stall = (r_state != S_RUN);
    assign accept_in  = i_in_valid && !o_in_stall;
    assign count_go   = accept_in && !i_operation && (r_byte_total != TOTAL_MAX);
    assign rep_go     = accept_in && i_operation;
    assign out_take   = o_out_valid && !i_out_stall;

    assign cnt_lane = r_byte_total[LANE_W-1:0];
    assign cnt_addr = {cnt_lane, i_data_byte};
    assign pa       = f_pair_a(r_pair);
    assign pb       = f_pair_b(r_pair);
    assign raddr0   = (r_state == S_RUN) ? cnt_addr : {pa, r_bin};
    assign raddr1   = {pb, r_bin};

    assign old_cnt = r_c_fwd ? r_c_fwd_val : rdata0;
    assign inc_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + COUNT_BITS'(1);
    assign we      = (r_state == S_CLEAR) || r_c_valid;
    assign waddr   = (r_state == S_CLEAR) ? r_clr_addr : r_c_addr;
    assign wdata   = (r_state == S_CLEAR) ? '0 : inc_cnt;

    assign mac_ctl.clr   = rep_go || (out_take && r_pair != LAST_PAIR);
    assign mac_ctl.valid = r_rv;

    lbhc_hist_mem u_mem (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (rdata0),
        .o_rdata1 (rdata1)
    );

    lbhc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_cnt_a (rdata0),
        .i_cnt_b (rdata1),
        .o_sum   (mac_sum),
        .o_busy  (mac_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_byte_total <= '0;
            r_c_valid    <= 1'b0;
            r_c_fwd      <= 1'b0;
            r_rv         <= 1'b0;
            r_pair       <= '0;
            r_bin        <= '0;
            o_out_valid  <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                r_lane_min[i] <= 8'hFF;
                r_lane_max[i] <= 8'h00;
            end
        end else begin
            r_c_valid <= count_go;
            // The memory returns the old value when the bin written this cycle is read.
            r_c_fwd   <= count_go && r_c_valid && (r_c_addr == cnt_addr);
            r_rv      <= (r_state == S_RD);
            if (count_go) begin
                r_byte_total <= r_byte_total + TOTAL_W'(1);
                if (i_data_byte < r_lane_min[cnt_lane]) begin
                    r_lane_min[cnt_lane] <= i_data_byte;
                end
                if (i_data_byte > r_lane_max[cnt_lane]) begin
                    r_lane_max[cnt_lane] <= i_data_byte;
                end
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (rep_go) begin
                        r_state <= S_RD;
                        r_pair  <= '0;
                        r_bin   <= '0;
                    end
                end
                S_RD: begin
                    r_bin <= r_bin + BIN_W'(1);
                    if (r_bin == BIN_W'(BINS - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_rv && !mac_busy) begin
                        o_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        o_out_valid <= 1'b0;
                        if (r_pair == LAST_PAIR) begin
                            r_state <= S_RUN;
                        end else begin
                            r_pair  <= r_pair + PAIR_W'(1);
                            r_bin   <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                default: r_state <= S_RUN;
            endcase
        end
        r_c_addr    <= cnt_addr;
        r_c_fwd_val <= inc_cnt;
        if (r_state == S_DRAIN) begin
            o_lane_a      <= pa;
            o_lane_b      <= pb;
            o_product_sum <= mac_sum;
            o_total_a     <= f_lane_total(r_byte_total, pa);
            o_total_b     <= f_lane_total(r_byte_total, pb);
            o_min_a       <= r_lane_min[pa];
            o_max_a       <= r_lane_max[pa];
            o_last        <= (r_pair == LAST_PAIR);
        end
    end

endmodule

// ===== rtl/core/lbhc_checker.sv =====
// Port-level checks of the lane byte histogram correlator, bound to the top level.
// Depends on lane_byte_histogram_correlator_assert.svh.
module lbhc_assert_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_lane_a,
    input logic [1:0]  o_lane_b,
    input logic [63:0] o_product_sum,
    input logic [31:0] o_total_a,
    input logic [7:0]  o_min_a,
    input logic [7:0]  o_max_a,
    input logic        o_last
);
`include "lane_byte_histogram_correlator_assert.svh"

    `LBHC_ASSERT_NOW(a_pair_order, o_out_valid, o_lane_b >= o_lane_a, "lane_b below lane_a")
    `LBHC_ASSERT_NOW(a_last_pair, o_out_valid && o_last,
        o_lane_a == 2'd2 && o_lane_b == 2'd3, "last word is not pair 2 and 3")
    `LBHC_ASSERT_NOW(a_empty_lane, o_out_valid && o_total_a == 32'd0,
        o_product_sum == 64'd0 && o_min_a == 8'hFF && o_max_a == 8'h00,
        "empty lane reports data")
    `LBHC_ASSERT_NOW(a_minmax, o_out_valid && o_total_a != 32'd0, o_min_a <= o_max_a,
        "min above max")
    `LBHC_ASSERT_NEXT(a_intake_held, o_out_valid && i_out_stall, o_in_stall,
        "intake open during report")

endmodule

bind lane_byte_histogram_correlator lbhc_assert_checker u_lbhc_checker (.*);
